@@ hdl/bdeq_pkg.sv @@
// ----------------------------------------------------------------------------
// bdeq_pkg
// Types and codes shared by the bounded array deque and its testbench-free
// companions: request and result payloads, request kinds, status codes.
// ----------------------------------------------------------------------------
package bdeq_pkg;

    localparam int WORD_W = 32;

    typedef enum logic [1:0] {
        KIND_INS_REAR  = 2'd0,
        KIND_INS_FRONT = 2'd1,
        KIND_DEL_REAR  = 2'd2,
        KIND_DEL_FRONT = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_REFUSED = 2'd1,
        ST_EMPTY   = 2'd2
    } t_status;

    typedef struct packed {
        t_kind                     kind;
        logic signed [WORD_W-1:0]  value;
    } t_req;

    typedef struct packed {
        logic signed [WORD_W-1:0]  read_value;
        t_status                   status;
    } t_rsp;

endpackage

@@ hdl/bdeq_ram.sv @@
// ----------------------------------------------------------------------------
// bdeq_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module bdeq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/bounded_array_deque_top.sv @@
// ----------------------------------------------------------------------------
// bounded_array_deque_top
// Double-ended queue held in a non-wrapping array, addressed by a front and
// an end index.
// ----------------------------------------------------------------------------
// A request is taken when i_start is high and o_busy is low; o_busy is high
// only in reset and until the ready flag is set after it. Each request gives
// exactly one result on o_result, flagged by o_done, in the cycle after the
// transfer, so one request can be taken every cycle. The index compare and
// update finish in the transfer cycle and the slot memory's registered read
// is what delays the result. A rear insert is refused once the end index
// reaches DEPTH, a front insert once the front index is 0; indices are never
// moved back when the queue empties.
module bounded_array_deque_top #(
    parameter int DEPTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  bdeq_pkg::t_req i_req,
    output logic           o_busy,
    output logic           o_done,
    output bdeq_pkg::t_rsp o_result
);

    localparam int IDX_W = $clog2(DEPTH + 1);
    localparam int AW    = $clog2(DEPTH);
    localparam logic [IDX_W-1:0] FULL_IDX = IDX_W'(DEPTH);

    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail, n_tail;
    logic             r_ready;
    logic             r_done;
    logic             r_rd_sel, n_rd_sel;
    bdeq_pkg::t_status r_status, n_status;

    logic             accept;
    logic             empty;
    logic             we, re;
    logic [AW-1:0]    waddr, raddr;
    logic [IDX_W-1:0] head_dec, tail_dec;
    logic [bdeq_pkg::WORD_W-1:0] rdata;

    assign accept   = i_start && r_ready;
    assign empty    = (r_head == r_tail);
    assign head_dec = r_head - IDX_W'(1);
    assign tail_dec = r_tail - IDX_W'(1);

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_rd_sel = 1'b0;
        n_status = bdeq_pkg::ST_DONE;
        we       = 1'b0;
        re       = 1'b0;
        waddr    = r_tail[AW-1:0];
        raddr    = r_head[AW-1:0];
        case (i_req.kind)
            bdeq_pkg::KIND_INS_REAR: begin
                if (r_tail == FULL_IDX) begin
                    n_status = bdeq_pkg::ST_REFUSED;
                end else begin
                    we     = accept;
                    waddr  = r_tail[AW-1:0];
                    n_tail = r_tail + IDX_W'(1);
                end
            end
            bdeq_pkg::KIND_INS_FRONT: begin
                if (r_head == '0) begin
                    n_status = bdeq_pkg::ST_REFUSED;
                end else begin
                    we     = accept;
                    waddr  = head_dec[AW-1:0];
                    n_head = head_dec;
                end
            end
            bdeq_pkg::KIND_DEL_REAR: begin
                if (empty) begin
                    n_status = bdeq_pkg::ST_EMPTY;
                end else begin
                    re       = accept;
                    raddr    = tail_dec[AW-1:0];
                    n_tail   = tail_dec;
                    n_rd_sel = 1'b1;
                end
            end
            bdeq_pkg::KIND_DEL_FRONT: begin
                if (empty) begin
                    n_status = bdeq_pkg::ST_EMPTY;
                end else begin
                    re       = accept;
                    raddr    = r_head[AW-1:0];
                    n_head   = r_head + IDX_W'(1);
                    n_rd_sel = 1'b1;
                end
            end
            default: begin
                n_status = bdeq_pkg::ST_EMPTY;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_ready  <= 1'b0;
            r_done   <= 1'b0;
            r_rd_sel <= 1'b0;
            r_status <= bdeq_pkg::ST_DONE;
        end else begin
            r_ready <= 1'b1;
            r_done  <= accept;
            if (accept) begin
                r_head   <= n_head;
                r_tail   <= n_tail;
                r_rd_sel <= n_rd_sel;
                r_status <= n_status;
            end
        end
    end

    // write lands at the transfer edge, so a read of the same slot on the
    // next request already sees it
    bdeq_ram #(
        .WIDTH (bdeq_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_req.value),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_busy              = !r_ready;
    assign o_done              = r_done;
    assign o_result.read_value = r_rd_sel ? rdata : '0;
    assign o_result.status     = r_status;

    a_idx_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail)
        else $error("front index passed end index");

    a_tail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail <= FULL_IDX)
        else $error("end index beyond array");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_done)
        else $error("transfer without result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_start && !o_busy) |=> !o_done)
        else $error("result without transfer");

    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status != bdeq_pkg::ST_DONE) |-> o_result.read_value == '0)
        else $error("nonzero read value on failed request");

endmodule
